[design/sdrm_pkg.sv]
// Shared types and codes for the signed divider with rounding modes.
package sdrm_pkg;

   // rounding mode codes
   typedef enum logic [3:0] {
      MODE_TO_ZERO      = 4'd0,
      MODE_AWAY_ZERO    = 4'd1,
      MODE_TO_INF       = 4'd2,
      MODE_TO_NEG_INF   = 4'd3,
      MODE_TO_ODD       = 4'd4,
      MODE_TO_EVEN      = 4'd5,
      MODE_TIES_ZERO    = 4'd6,
      MODE_TIES_AWAY    = 4'd7,
      MODE_TIES_INF     = 4'd8,
      MODE_TIES_NEG_INF = 4'd9,
      MODE_TIES_ODD     = 4'd10,
      MODE_TIES_EVEN    = 4'd11
   } mode_type;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // side info carried along the divider stages
   typedef struct packed {
      logic [3:0] mode;
      logic       neg;
      logic       xn;
      logic [1:0] status;
   } side_type;

endpackage

[design/signed_divider_rounding_modes_core.sv]
// Top level: pipelined signed divider with twelve rounding modes.
//
//  channel | dir | fields (tdata/tuser, low bit first)
//  req     | in  | tdata: dividend, divisor; tuser: req_type
//  rsp     | out | tdata: quotient, remainder, status (zero filled)
//
// The pipeline has one entry stage, WIDTH one-bit divide stages and
// one rounding stage. One request is accepted every cycle unless the output stalls.
// Synchronous reset clears all valid bits; payload is not reset.
// A stalled result freezes the whole pipeline; ready is the output's
// ready or an empty output slot, so no request is lost or repeated.
module signed_divider_rounding_modes_core
   import sdrm_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2*WIDTH-1:0]       req_tdata,   // dividend, divisor
   input  logic [3:0]               req_tuser,   // req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((2*WIDTH+2+7)/8)*8-1:0] rsp_tdata // quotient, remainder, status
);

   localparam int OW = ((2*WIDTH+2+7)/8)*8;

   logic             stall;
   logic             e_valid_ff;
   logic [WIDTH-1:0] e_ux_ff, e_uy_ff, e_y_ff;
   side_type         e_side_ff, e_side_in;
   logic [WIDTH-1:0] x, y;

   logic             v   [WIDTH+1];
   logic [WIDTH-1:0] rem [WIDTH+1];
   logic [WIDTH-1:0] quo [WIDTH+1];
   logic [WIDTH-1:0] dvs [WIDTH+1];
   logic [WIDTH-1:0] yy  [WIDTH+1];
   side_type         sd  [WIDTH+1];

   logic             o_valid;
   logic [WIDTH-1:0] o_quo, o_rem;
   logic [1:0]       o_status;

   assign stall      = rsp_tvalid && !rsp_tready;
   assign req_tready = !stall;

   // entry stage: magnitudes and special cases
   assign x = req_tdata[WIDTH-1:0];
   assign y = req_tdata[2*WIDTH-1:WIDTH];
   always_comb begin
      e_side_in.mode = req_tuser;
      e_side_in.xn   = x[WIDTH-1];
      e_side_in.neg  = x[WIDTH-1] ^ y[WIDTH-1];
      if (y == '0) begin
         e_side_in.status = STATUS_DIV_ZERO;
      end else if (x == {1'b1, {(WIDTH-1){1'b0}}} && y == '1) begin
         e_side_in.status = STATUS_OVERFLOW;
      end else begin
         e_side_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (!stall) begin
         e_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         e_ux_ff   <= x[WIDTH-1] ? (~x + 1'b1) : x;
         e_uy_ff   <= y[WIDTH-1] ? (~y + 1'b1) : y;
         e_y_ff    <= y;
         e_side_ff <= e_side_in;
      end
   end

   assign v[0]   = e_valid_ff;
   assign rem[0] = '0;
   assign quo[0] = e_ux_ff;
   assign dvs[0] = e_uy_ff;
   assign yy[0]  = e_y_ff;
   assign sd[0]  = e_side_ff;

   // one stage per quotient bit
   for (genvar i = 0; i < WIDTH; i++) begin : g_div
      sdrm_div_stage #(.WIDTH(WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .stall     (stall),
         .valid_in  (v[i]),
         .rem_in    (rem[i]),
         .quo_in    (quo[i]),
         .dvs_in    (dvs[i]),
         .y_in      (yy[i]),
         .side_in   (sd[i]),
         .valid_out (v[i+1]),
         .rem_out   (rem[i+1]),
         .quo_out   (quo[i+1]),
         .dvs_out   (dvs[i+1]),
         .y_out     (yy[i+1]),
         .side_out  (sd[i+1])
      );
   end

   sdrm_round #(.WIDTH(WIDTH)) u_round (
      .clock     (clock),
      .reset     (reset),
      .stall     (stall),
      .valid_in  (v[WIDTH]),
      .qm        (quo[WIDTH]),
      .rm        (rem[WIDTH]),
      .uy        (dvs[WIDTH]),
      .y         (yy[WIDTH]),
      .side_in   (sd[WIDTH]),
      .valid_out (o_valid),
      .quotient  (o_quo),
      .remainder (o_rem),
      .status    (o_status)
   );

   assign rsp_tvalid = o_valid;
   assign rsp_tdata  = {{(OW-2*WIDTH-2){1'b0}}, o_status, o_rem, o_quo};

`ifndef NO_ASSERTIONS
   // a divide by zero result is all zero
   a_divz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_status == STATUS_DIV_ZERO |-> o_quo == '0 && o_rem == '0)
      else $error("divide by zero result not zero");
   // status never takes the unused code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> o_status <= STATUS_OVERFLOW)
      else $error("bad status code");
   // a stall holds the result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
`endif

endmodule

[design/sdrm_div_stage.sv]
// One restoring division step stage: shifts in one dividend bit per cycle unless stalled.
module sdrm_div_stage
   import sdrm_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             stall,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] rem_in,
   input  logic [WIDTH-1:0] quo_in,
   input  logic [WIDTH-1:0] dvs_in,
   input  logic [WIDTH-1:0] y_in,
   input  side_type         side_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] rem_out,
   output logic [WIDTH-1:0] quo_out,
   output logic [WIDTH-1:0] dvs_out,
   output logic [WIDTH-1:0] y_out,
   output side_type         side_out
);

   logic             valid_ff;
   logic [WIDTH-1:0] rem_ff, rem_in_w, quo_ff, quo_in_w, dvs_ff, y_ff;
   side_type         side_ff;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // shift the next dividend bit in and try subtracting
   always_comb begin
      trial    = {rem_in, quo_in[WIDTH-1]};
      diff     = trial - {1'b0, dvs_in};
      if (!diff[WIDTH]) begin
         rem_in_w = diff[WIDTH-1:0];
         quo_in_w = {quo_in[WIDTH-2:0], 1'b1};
      end else begin
         rem_in_w = trial[WIDTH-1:0];
         quo_in_w = {quo_in[WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         rem_ff  <= rem_in_w;
         quo_ff  <= quo_in_w;
         dvs_ff  <= dvs_in;
         y_ff    <= y_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign dvs_out   = dvs_ff;
   assign y_out     = y_ff;
   assign side_out  = side_ff;

endmodule

[design/sdrm_round.sv]
// Rounding stage: picks the quotient offset and fixes the remainder.
module sdrm_round
   import sdrm_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             stall,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] qm,
   input  logic [WIDTH-1:0] rm,
   input  logic [WIDTH-1:0] uy,
   input  logic [WIDTH-1:0] y,
   input  side_type         side_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder,
   output logic [1:0]       status
);

   logic             valid_ff;
   logic [WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, qa, r0;
   logic [1:0]       status_ff;
   logic [WIDTH:0]   twice;
   logic             nz, qodd, above, tie, inc;

   // offset decision per mode
   always_comb begin
      nz    = (rm != '0);
      qodd  = qm[0];
      twice = {rm, 1'b0};
      above = twice > {1'b0, uy};
      tie   = twice == {1'b0, uy};
      unique case (side_in.mode)
         MODE_AWAY_ZERO:    inc = nz;
         MODE_TO_INF:       inc = nz && !side_in.neg;
         MODE_TO_NEG_INF:   inc = nz && side_in.neg;
         MODE_TO_ODD:       inc = nz && !qodd;
         MODE_TO_EVEN:      inc = nz && qodd;
         MODE_TIES_ZERO:    inc = above;
         MODE_TIES_AWAY:    inc = above || tie;
         MODE_TIES_INF:     inc = above || (tie && !side_in.neg);
         MODE_TIES_NEG_INF: inc = above || (tie && side_in.neg);
         MODE_TIES_ODD:     inc = above || (tie && !qodd);
         MODE_TIES_EVEN:    inc = above || (tie && qodd);
         default:           inc = 1'b0;
      endcase
      qa = qm + {{(WIDTH-1){1'b0}}, inc};
      r0 = side_in.xn ? (~rm + 1'b1) : rm;
      if (side_in.status == STATUS_DIV_ZERO) begin
         quo_in = '0;
         rem_in = '0;
      end else if (side_in.status == STATUS_OVERFLOW) begin
         quo_in = {1'b1, {(WIDTH-1){1'b0}}};
         rem_in = '0;
      end else begin
         quo_in = side_in.neg ? (~qa + 1'b1) : qa;
         if (!inc) begin
            rem_in = r0;
         end else if (side_in.neg) begin
            rem_in = r0 + y;
         end else begin
            rem_in = r0 - y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         quo_ff    <= quo_in;
         rem_ff    <= rem_in;
         status_ff <= side_in.status;
      end
   end

   assign valid_out = valid_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign status    = status_ff;

endmodule
